// File: design/rbt_pkg.sv
// shared constants, field widths and operation codes of the bitmap tracker
// no dependencies; compile first
`default_nettype none

package rbt_pkg;

    // default sizing of the bitmap
    localparam int DEF_MAX_BITS  = 4096;
    localparam int DEF_WORD_BITS = 64;

    // field widths on the channels
    localparam int MODE_W     = 3;
    localparam int IDX_W      = 16;
    localparam int KIND_W     = 2;
    localparam int OUT_WORD_W = 64;

    // width of a value handed to the word locator (bit index or length up to 65536)
    localparam int VAL_W       = 17;
    localparam int RECIP_SHIFT = 24;

    // result limit per command
    localparam int RESULT_LIMIT = 64;
    localparam int RES_CNT_W    = 7;

    // command modes
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FSET   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESIZE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INIT   = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GROW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TEST = 2'd3;

endpackage

`default_nettype wire

// File: design/rbt_ifs.sv
// valid/ready channel interfaces: command in, event out, configuration write
// depends on rbt_pkg
`default_nettype none

interface rbt_cmd_if import rbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  bit_index;
    logic [IDX_W-1:0]  new_length;

    modport source (output valid, output mode, output bit_index, output new_length,
                    input ready);
    modport sink   (input valid, input mode, input bit_index, input new_length,
                    output ready);
endinterface

interface rbt_evt_if import rbt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [IDX_W-1:0]      position;
    logic [OUT_WORD_W-1:0] word_bits;
    logic                  answer;
    logic                  last;

    modport source (output valid, output kind, output position, output word_bits,
                    output answer, output last, input ready);
    modport sink   (input valid, input kind, input position, input word_bits,
                    input answer, input last, output ready);
endinterface

interface rbt_cfg_if import rbt_pkg::*; ();
    logic valid;
    logic ready;
    logic fill_beyond;

    modport source (output valid, output fill_beyond, input ready);
    modport sink   (input valid, input fill_beyond, output ready);
endinterface

`default_nettype wire

// File: design/rbt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/rbt_word_locator.sv
// shared word locator: splits a bit position into word number and offset
// two-stage pipeline (reciprocal multiply, then multiply back and correct); uses rbt_pkg
`default_nettype none

module rbt_word_locator import rbt_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS,
    localparam int OFF_W = $clog2(WORD_BITS)
) (
    input  logic             clk,
    input  logic [VAL_W-1:0] value,
    output logic [VAL_W-1:0] quo,
    output logic [OFF_W-1:0] rem
);

    localparam int PROD_W = VAL_W + RECIP_SHIFT;
    localparam int BACK_W = VAL_W + OFF_W + 1;
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((1 << RECIP_SHIFT) / WORD_BITS);
    localparam logic [OFF_W:0] WB = (OFF_W + 1)'(WORD_BITS);

    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  q0_reg, q0_next;
    logic [VAL_W-1:0]  v1_reg;
    logic [BACK_W-1:0] back;
    logic [VAL_W-1:0]  diff;
    logic [VAL_W-1:0]  quo_reg, quo_next;
    logic [OFF_W-1:0]  rem_reg, rem_next;

    // estimate is at most one below the true quotient
    assign prod    = PROD_W'(value) * PROD_W'(RECIP);
    assign q0_next = prod[RECIP_SHIFT +: VAL_W];

    assign back = BACK_W'(q0_reg) * BACK_W'(WB);
    assign diff = v1_reg - back[VAL_W-1:0];

    always_comb
    begin
        if (diff[OFF_W:0] >= WB)
        begin
            quo_next = q0_reg + VAL_W'(1);
            rem_next = OFF_W'(diff[OFF_W:0] - WB);
        end
        else
        begin
            quo_next = q0_reg;
            rem_next = diff[OFF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg  <= q0_next;
        v1_reg  <= value;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo = quo_reg;
    assign rem = rem_reg;

endmodule

`default_nettype wire

// File: design/resizable_bitmap_tracker.sv
// resizable presence bitmap: set, forced set, test, resize, list and init on one bitmap
// set/forced set/test: locate the bit, read-modify-write it, then show any held word with last;
// resize and list: walk the range word by word, then show any final word with last; init
// writes every word, no-op commands go straight to the final state; one command in flight, a full output
// register stalls the walk; reset: rst_n async low clears control state, then a clearing
// pass zeroes the ram before the first command (config taken throughout)
`default_nettype none

module resizable_bitmap_tracker import rbt_pkg::*; #(
    parameter int MAX_BITS  = DEF_MAX_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    rbt_cmd_if.sink     cmd,
    rbt_evt_if.source   evt,
    rbt_cfg_if.sink     cfg
);

    // sizing derived from the parameters
    localparam int NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WCW    = $clog2(NWORDS + 1);
    localparam int LEN_W  = $clog2(MAX_BITS + 1);
    localparam int OFF_W  = $clog2(WORD_BITS);

    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_BITS);
    localparam logic [WCW-1:0]   LAST_WORD = WCW'(NWORDS - 1);
    localparam logic [OFF_W:0]   WB_FULL   = (OFF_W + 1)'(WORD_BITS);
    localparam logic [IDX_W-1:0] WB_STEP   = IDX_W'(WORD_BITS);

    typedef enum logic [3:0] {
        ST_CLEAR,   // zeroing pass after reset
        ST_IDLE,
        ST_LOCA,    // feed first position to the locator
        ST_LOCB,    // feed last position of the range
        ST_LOCC,    // first position located
        ST_LOCD,    // last position located
        ST_RMW,     // single-bit read-modify-write
        ST_WRD,     // walk: read word
        ST_WOP,     // walk: report or fill word
        ST_INIT,    // init: write every word
        ST_FIN      // release the held word with last set
    } state_t;

    typedef enum logic [2:0] {
        OP_SET, OP_FSET, OP_TEST, OP_GROW, OP_FILL, OP_LIST, OP_INIT, OP_NONE
    } op_t;

    // sequencer and command registers
    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic                fill_reg, fill_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic [IDX_W-1:0]    bit_reg, bit_next;
    logic [LEN_W-1:0]    lo_reg, lo_next;
    logic [LEN_W-1:0]    hi_reg, hi_next;

    // walk registers
    logic [WCW-1:0]      w_reg, w_next;
    logic [WCW-1:0]      wfirst_reg, wfirst_next;
    logic [WCW-1:0]      wlast_reg, wlast_next;
    logic [OFF_W-1:0]    off_lo_reg, off_lo_next;
    logic [OFF_W-1:0]    off_hi_reg, off_hi_next;
    logic [IDX_W-1:0]    base_reg, base_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    // held word: kept back one step so that last can be known
    logic                  pend_vld_reg, pend_vld_next;
    logic [KIND_W-1:0]     pend_kind_reg, pend_kind_next;
    logic [IDX_W-1:0]      pend_pos_reg, pend_pos_next;
    logic [OUT_WORD_W-1:0] pend_bits_reg, pend_bits_next;
    logic                  pend_ans_reg, pend_ans_next;

    // output register
    logic                  out_vld_reg, out_vld_next;
    logic [KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic [IDX_W-1:0]      out_pos_reg, out_pos_next;
    logic [OUT_WORD_W-1:0] out_bits_reg, out_bits_next;
    logic                  out_ans_reg, out_ans_next;
    logic                  out_last_reg, out_last_next;

    // locator and ram connections
    logic [VAL_W-1:0]     loc_in;
    logic [VAL_W-1:0]     loc_quo;
    logic [OFF_W-1:0]     loc_rem;
    logic                 ram_wr_en;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    // datapath helpers
    logic [LEN_W-1:0]     nl_sat;
    logic [OFF_W:0]       cut_lo;
    logic [OFF_W:0]       cut_hi;
    logic [WORD_BITS-1:0] walk_mask;
    logic [WORD_BITS-1:0] walk_sel;
    logic [WORD_BITS-1:0] init_word;
    logic [WORD_BITS-1:0] bit_onehot;
    logic                 in_range;
    logic                 old_bit;
    logic                 walk_hit;
    logic                 slot_free;

    // bits below n set, the rest clear
    function automatic logic [WORD_BITS-1:0] below_mask(input logic [OFF_W:0] n);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            m[i] = ((OFF_W + 1)'(i) < n);
        end
        return m;
    endfunction

    rbt_word_locator #(
        .WORD_BITS (WORD_BITS)
    ) u_locator (
        .clk   (clk),
        .value (loc_in),
        .quo   (loc_quo),
        .rem   (loc_rem)
    );

    rbt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (w_reg[AW-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // requested length saturates at the bitmap size
    assign nl_sat = (VAL_W'(cmd.new_length) > VAL_W'(MAX_BITS)) ? MAX_LEN
                                                                : LEN_W'(cmd.new_length);

    // second locator feed is the last bit of the range, the first is bit or range start
    always_comb
    begin
        if (state_reg == ST_LOCB)
        begin
            loc_in = VAL_W'(hi_reg) - VAL_W'(1);
        end
        else if (op_reg == OP_SET || op_reg == OP_FSET || op_reg == OP_TEST)
        begin
            loc_in = VAL_W'(bit_reg);
        end
        else
        begin
            loc_in = VAL_W'(lo_reg);
        end
    end

    // range mask of the word under the walk: clipped at the first and last words
    assign cut_lo    = (w_reg == wfirst_reg) ? {1'b0, off_lo_reg} : '0;
    assign cut_hi    = (w_reg == wlast_reg) ? ({1'b0, off_hi_reg} + (OFF_W + 1)'(1)) : WB_FULL;
    assign walk_mask = below_mask(cut_hi) & ~below_mask(cut_lo);
    assign walk_sel  = ram_rd_data & walk_mask;
    assign walk_hit  = (walk_sel != '0) && (res_cnt_reg < RES_CNT_W'(RESULT_LIMIT));

    // init contents: clear below the length, fill value at and above it
    always_comb
    begin
        if (w_reg < wlast_reg)
        begin
            init_word = '0;
        end
        else if (w_reg == wlast_reg)
        begin
            init_word = fill_reg ? ~below_mask({1'b0, off_hi_reg}) : '0;
        end
        else
        begin
            init_word = fill_reg ? '1 : '0;
        end
    end

    // single-bit access
    assign in_range   = VAL_W'(bit_reg) < VAL_W'(length_reg);
    assign old_bit    = ram_rd_data[off_lo_reg];
    assign bit_onehot = WORD_BITS'(1) << off_lo_reg;

    // output register can take a word this cycle
    assign slot_free = !out_vld_reg || evt.ready;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        fill_next      = fill_reg;
        length_next    = length_reg;
        bit_next       = bit_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        w_next         = w_reg;
        wfirst_next    = wfirst_reg;
        wlast_next     = wlast_reg;
        off_lo_next    = off_lo_reg;
        off_hi_next    = off_hi_reg;
        base_next      = base_reg;
        res_cnt_next   = res_cnt_reg;
        pend_vld_next  = pend_vld_reg;
        pend_kind_next = pend_kind_reg;
        pend_pos_next  = pend_pos_reg;
        pend_bits_next = pend_bits_reg;
        pend_ans_next  = pend_ans_reg;
        out_vld_next   = out_vld_reg;
        out_kind_next  = out_kind_reg;
        out_pos_next   = out_pos_reg;
        out_bits_next  = out_bits_reg;
        out_ans_next   = out_ans_reg;
        out_last_next  = out_last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = w_reg[AW-1:0];

        if (cfg.valid)
        begin
            fill_next = cfg.fill_beyond;
        end

        // word taken downstream
        if (out_vld_reg && evt.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                if (w_reg == LAST_WORD)
                begin
                    w_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    w_next = w_reg + WCW'(1);
                end
            end

            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    bit_next     = cmd.bit_index;
                    res_cnt_next = '0;
                    state_next   = ST_LOCA;
                    case (cmd.mode)
                        MODE_SET:
                        begin
                            op_next = OP_SET;
                        end
                        MODE_FSET:
                        begin
                            op_next = OP_FSET;
                        end
                        MODE_TEST:
                        begin
                            op_next = OP_TEST;
                        end
                        MODE_RESIZE:
                        begin
                            length_next = nl_sat;
                            if (nl_sat > length_reg)
                            begin
                                // grow reports the added range
                                op_next = OP_GROW;
                                lo_next = length_reg;
                                hi_next = nl_sat;
                            end
                            else if (nl_sat < length_reg && fill_reg)
                            begin
                                // shrink with fill marks the removed range
                                op_next = OP_FILL;
                                lo_next = nl_sat;
                                hi_next = length_reg;
                            end
                            else
                            begin
                                op_next    = OP_NONE;
                                state_next = ST_FIN;
                            end
                        end
                        MODE_LIST:
                        begin
                            lo_next = '0;
                            hi_next = length_reg;
                            if (length_reg != '0)
                            begin
                                op_next = OP_LIST;
                            end
                            else
                            begin
                                op_next    = OP_NONE;
                                state_next = ST_FIN;
                            end
                        end
                        MODE_INIT:
                        begin
                            op_next     = OP_INIT;
                            lo_next     = nl_sat;
                            length_next = nl_sat;
                        end
                        default:
                        begin
                            // unused modes are dropped
                            op_next    = OP_NONE;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_LOCA:
            begin
                state_next = ST_LOCB;
            end

            ST_LOCB:
            begin
                state_next = ST_LOCC;
            end

            ST_LOCC:
            begin
                off_lo_next = loc_rem;
                w_next      = loc_quo[WCW-1:0];
                wfirst_next = loc_quo[WCW-1:0];
                case (op_reg)
                    OP_SET, OP_FSET, OP_TEST:
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = loc_quo[AW-1:0];
                        state_next  = ST_RMW;
                    end
                    OP_INIT:
                    begin
                        // word holding the new length, walk starts at word zero
                        wlast_next  = loc_quo[WCW-1:0];
                        off_hi_next = loc_rem;
                        w_next      = '0;
                        state_next  = ST_INIT;
                    end
                    default:
                    begin
                        state_next = ST_LOCD;
                    end
                endcase
            end

            ST_LOCD:
            begin
                wlast_next  = loc_quo[WCW-1:0];
                off_hi_next = loc_rem;
                base_next   = IDX_W'(lo_reg) - IDX_W'(off_lo_reg);
                state_next  = ST_WRD;
            end

            ST_RMW:
            begin
                if (op_reg == OP_TEST)
                begin
                    pend_vld_next  = 1'b1;
                    pend_kind_next = KIND_TEST;
                    pend_pos_next  = bit_reg;
                    pend_bits_next = '0;
                    pend_ans_next  = in_range ? old_bit : 1'b1;
                end
                else
                begin
                    if (in_range)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data | bit_onehot;
                    end
                    // forced set reports even when nothing changed
                    if (op_reg == OP_FSET || (in_range && !old_bit))
                    begin
                        pend_vld_next  = 1'b1;
                        pend_kind_next = KIND_BIT;
                        pend_pos_next  = bit_reg;
                        pend_bits_next = '0;
                        pend_ans_next  = 1'b0;
                    end
                end
                state_next = ST_FIN;
            end

            ST_WRD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_WOP;
            end

            ST_WOP:
            begin
                // stall while a new word needs the slot the held word has to leave by
                if (!(op_reg != OP_FILL && walk_hit && pend_vld_reg && !slot_free))
                begin
                    if (op_reg == OP_FILL)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data | walk_mask;
                    end
                    else if (walk_hit)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_kind_next = pend_kind_reg;
                            out_pos_next  = pend_pos_reg;
                            out_bits_next = pend_bits_reg;
                            out_ans_next  = pend_ans_reg;
                            out_last_next = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_kind_next = (op_reg == OP_GROW) ? KIND_GROW : KIND_LIST;
                        pend_pos_next  = base_reg;
                        pend_bits_next = OUT_WORD_W'(walk_sel);
                        pend_ans_next  = 1'b0;
                        res_cnt_next   = res_cnt_reg + RES_CNT_W'(1);
                    end

                    if (w_reg == wlast_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        w_next     = w_reg + WCW'(1);
                        base_next  = base_reg + WB_STEP;
                        state_next = ST_WRD;
                    end
                end
            end

            ST_INIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = init_word;
                if (w_reg == LAST_WORD)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    w_next = w_reg + WCW'(1);
                end
            end

            ST_FIN:
            begin
                if (pend_vld_reg)
                begin
                    if (slot_free)
                    begin
                        out_vld_next  = 1'b1;
                        out_kind_next = pend_kind_reg;
                        out_pos_next  = pend_pos_reg;
                        out_bits_next = pend_bits_reg;
                        out_ans_next  = pend_ans_reg;
                        out_last_next = 1'b1;
                        pend_vld_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= OP_NONE;
            fill_reg      <= 1'b0;
            length_reg    <= '0;
            bit_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            w_reg         <= '0;
            wfirst_reg    <= '0;
            wlast_reg     <= '0;
            off_lo_reg    <= '0;
            off_hi_reg    <= '0;
            base_reg      <= '0;
            res_cnt_reg   <= '0;
            pend_vld_reg  <= 1'b0;
            pend_kind_reg <= '0;
            pend_pos_reg  <= '0;
            pend_bits_reg <= '0;
            pend_ans_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            out_kind_reg  <= '0;
            out_pos_reg   <= '0;
            out_bits_reg  <= '0;
            out_ans_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            fill_reg      <= fill_next;
            length_reg    <= length_next;
            bit_reg       <= bit_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            w_reg         <= w_next;
            wfirst_reg    <= wfirst_next;
            wlast_reg     <= wlast_next;
            off_lo_reg    <= off_lo_next;
            off_hi_reg    <= off_hi_next;
            base_reg      <= base_next;
            res_cnt_reg   <= res_cnt_next;
            pend_vld_reg  <= pend_vld_next;
            pend_kind_reg <= pend_kind_next;
            pend_pos_reg  <= pend_pos_next;
            pend_bits_reg <= pend_bits_next;
            pend_ans_reg  <= pend_ans_next;
            out_vld_reg   <= out_vld_next;
            out_kind_reg  <= out_kind_next;
            out_pos_reg   <= out_pos_next;
            out_bits_reg  <= out_bits_next;
            out_ans_reg   <= out_ans_next;
            out_last_reg  <= out_last_next;
        end
    end

    // event channel driven straight from the output register
    assign evt.valid     = out_vld_reg;
    assign evt.kind      = out_kind_reg;
    assign evt.position  = out_pos_reg;
    assign evt.word_bits = out_bits_reg;
    assign evt.answer    = out_ans_reg;
    assign evt.last      = out_last_reg;

`ifndef SYNTH
    // nothing may be held back once a command is finished
    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_vld_reg)
        else $error("held word left behind at idle");

    // length stays within the bitmap
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= MAX_LEN)
        else $error("length beyond bitmap size");

    // releasing the held word at the end shows it with last set
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && pend_vld_reg && slot_free) |=> (evt.valid && evt.last))
        else $error("final word not presented with last");

    // per-command result count never passes the limit
    a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_CNT_W'(RESULT_LIMIT))
        else $error("result count over limit");
`endif

endmodule

`default_nettype wire
